// ===== src/mte_pkg.sv =====
package mte_pkg;

  localparam int unsigned UnitW  = 12;
  localparam int unsigned DurW   = 15;
  localparam int unsigned CountW = 7;
  localparam int unsigned PcW    = 4;

  localparam logic [UnitW-1:0] UNIT_RESET = 12'd128;
  localparam logic [7:0]       SPACE_CODE = 8'd32;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_THREE = 2'd1,
    HELD_SEVEN = 2'd2
  } held_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_SKIP,
    C_SPACE,
    C_NOFIT,
    C_NOHELD,
    C_LAST_ELEM,
    C_NOT_EOT
  } cond_e;

  typedef enum logic [2:0] {
    A_NONE,
    A_UPGRADE,
    A_HALT,
    A_INC,
    A_COMMIT,
    A_CLEAR
  } act_e;

  typedef enum logic [1:0] {
    U_HELD,
    U_ELEM,
    U_ONE,
    U_SEVEN
  } units_e;

  // one microcode word
  typedef struct packed {
    logic           accept;
    logic           emit;
    units_e         units;
    logic           key_on;
    logic           last;
    act_e           act;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ucode_t;

  // sequencer -> datapath, already gated by output stall
  typedef struct packed {
    logic   accept;
    logic   emit;
    units_e units;
    logic   key_on;
    logic   last;
    act_e   act;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic no_req;
    logic out_busy;
    logic skip;
    logic space;
    logic nofit;
    logic noheld;
    logic last_elem;
    logic not_eot;
  } stat_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] len;
    logic [4:0] dash;
  } sym_t;

  // {len, dash}; letters A..Z then digits 0..9, dash bit i = element i
  localparam logic [7:0] SYM_TABLE [36] = '{
    {3'd2, 5'd2},  {3'd4, 5'd1},  {3'd4, 5'd5},  {3'd3, 5'd1},
    {3'd1, 5'd0},  {3'd4, 5'd4},  {3'd3, 5'd3},  {3'd4, 5'd0},
    {3'd2, 5'd0},  {3'd4, 5'd14}, {3'd3, 5'd5},  {3'd4, 5'd2},
    {3'd2, 5'd3},  {3'd2, 5'd1},  {3'd3, 5'd7},  {3'd4, 5'd6},
    {3'd4, 5'd11}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
    {3'd3, 5'd4},  {3'd4, 5'd8},  {3'd3, 5'd6},  {3'd4, 5'd9},
    {3'd4, 5'd13}, {3'd4, 5'd3},
    {3'd5, 5'd31}, {3'd5, 5'd30}, {3'd5, 5'd28}, {3'd5, 5'd24},
    {3'd5, 5'd16}, {3'd5, 5'd0},  {3'd5, 5'd1},  {3'd5, 5'd3},
    {3'd5, 5'd7},  {3'd5, 5'd15}
  };

  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t       s;
    logic [5:0] idx;
    logic       hit;
    begin
      hit = 1'b1;
      idx = '0;
      if (c >= 8'd48 && c <= 8'd57) begin
        idx = 6'(c - 8'd48) + 6'd26;
      end else if (c >= 8'd65 && c <= 8'd90) begin
        idx = 6'(c - 8'd65);
      end else if (c >= 8'd97 && c <= 8'd122) begin
        idx = 6'(c - 8'd97);
      end else begin
        hit = 1'b0;
      end
      s.valid = hit;
      s.len   = hit ? SYM_TABLE[idx][7:5] : 3'd0;
      s.dash  = hit ? SYM_TABLE[idx][4:0] : 5'd0;
      return s;
    end
  endfunction

endpackage

// ===== src/mte_if.sv =====
interface mte_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface mte_ival_if import mte_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [DurW-1:0] duration;
  logic            key_on;
  logic            last_interval;

  modport source (output valid, output duration, output key_on, output last_interval,
                  input ready);
  modport sink (input valid, input duration, input key_on, input last_interval,
                output ready);
endinterface

// ===== src/mte_sequencer.sv =====
module mte_sequencer import mte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  localparam logic [PcW-1:0] S_WAIT   = 4'd0;
  localparam logic [PcW-1:0] S_SKIP   = 4'd1;
  localparam logic [PcW-1:0] S_SPACE  = 4'd2;
  localparam logic [PcW-1:0] S_FIT    = 4'd3;
  localparam logic [PcW-1:0] S_HCHK   = 4'd4;
  localparam logic [PcW-1:0] S_HGAP   = 4'd5;
  localparam logic [PcW-1:0] S_ELEM   = 4'd6;
  localparam logic [PcW-1:0] S_EGAP   = 4'd7;
  localparam logic [PcW-1:0] S_COMMIT = 4'd8;
  localparam logic [PcW-1:0] S_EOT    = 4'd9;
  localparam logic [PcW-1:0] S_ECHK   = 4'd10;
  localparam logic [PcW-1:0] S_LAST   = 4'd11;
  localparam logic [PcW-1:0] S_CLR    = 4'd12;
  localparam logic [PcW-1:0] S_UPG    = 4'd13;
  localparam logic [PcW-1:0] S_HALT   = 4'd14;

  localparam ucode_t UC_NOP = '{accept: 1'b0, emit: 1'b0, units: U_ONE, key_on: 1'b0,
                                last: 1'b0, act: A_NONE, cond: C_NEVER, target: S_WAIT};

  function automatic ucode_t rom(input logic [PcW-1:0] a);
    ucode_t w;
    begin
      w = UC_NOP;
      unique case (a)
        S_WAIT:   begin w.accept = 1'b1; w.cond = C_NO_REQ; w.target = S_WAIT; end
        S_SKIP:   begin w.cond = C_SKIP; w.target = S_EOT; end
        S_SPACE:  begin w.cond = C_SPACE; w.target = S_UPG; end
        S_FIT:    begin w.cond = C_NOFIT; w.target = S_HALT; end
        S_HCHK:   begin w.cond = C_NOHELD; w.target = S_ELEM; end
        S_HGAP:   begin w.emit = 1'b1; w.units = U_HELD; end
        S_ELEM:   begin
          w.emit = 1'b1; w.units = U_ELEM; w.key_on = 1'b1;
          w.cond = C_LAST_ELEM; w.target = S_COMMIT;
        end
        S_EGAP:   begin
          w.emit = 1'b1; w.units = U_ONE; w.act = A_INC;
          w.cond = C_ALWAYS; w.target = S_ELEM;
        end
        S_COMMIT: begin w.act = A_COMMIT; end
        S_EOT:    begin w.cond = C_NOT_EOT; w.target = S_WAIT; end
        S_ECHK:   begin w.cond = C_NOHELD; w.target = S_CLR; end
        S_LAST:   begin w.emit = 1'b1; w.units = U_SEVEN; w.last = 1'b1; end
        S_CLR:    begin w.act = A_CLEAR; w.cond = C_ALWAYS; w.target = S_WAIT; end
        S_UPG:    begin w.act = A_UPGRADE; w.cond = C_ALWAYS; w.target = S_EOT; end
        S_HALT:   begin w.act = A_HALT; w.cond = C_ALWAYS; w.target = S_EOT; end
        default:  begin w.cond = C_ALWAYS; w.target = S_WAIT; end
      endcase
      return w;
    end
  endfunction

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         word;
  logic           stall;
  logic           take;

  always_comb begin
    word  = rom(pc_q);
    stall = word.emit && stat_i.out_busy;

    unique case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_REQ:    take = stat_i.no_req;
      C_SKIP:      take = stat_i.skip;
      C_SPACE:     take = stat_i.space;
      C_NOFIT:     take = stat_i.nofit;
      C_NOHELD:    take = stat_i.noheld;
      C_LAST_ELEM: take = stat_i.last_elem;
      C_NOT_EOT:   take = stat_i.not_eot;
      default:     take = 1'b1;
    endcase

    priority if (stall) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 4'd1;
    end

    ctrl_o.accept = word.accept;
    ctrl_o.emit   = word.emit && !stall;
    ctrl_o.units  = word.units;
    ctrl_o.key_on = word.key_on;
    ctrl_o.last   = word.last;
    ctrl_o.act    = stall ? A_NONE : word.act;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== src/mte_datapath.sv =====
module mte_datapath import mte_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  mte_char_if.sink         char_i,
  mte_ival_if.source       ival_o
);

  logic [UnitW-1:0]  unit_q;
  held_e             held_q, held_d;
  logic [CountW-1:0] count_q, count_d;
  logic              halt_q, halt_d;

  logic              eot_q;
  logic              is_space_q;
  logic              is_sym_q;
  logic [2:0]        len_q;
  logic [4:0]        dash_q;
  logic [2:0]        elem_q;

  logic              out_valid_q;
  logic [DurW-1:0]   dur_q;
  logic              key_q;
  logic              last_q;

  sym_t              sym;
  logic              req;
  logic [CountW:0]   need;
  logic [2:0]        units;

  assign sym = sym_lookup(char_i.char_code);
  assign req = char_i.valid && ctrl_i.accept;

  assign char_i.ready         = ctrl_i.accept;
  assign ival_o.valid         = out_valid_q;
  assign ival_o.duration      = dur_q;
  assign ival_o.key_on        = key_q;
  assign ival_o.last_interval = last_q;

  // intervals used so far plus this symbol and its trailing gap
  assign need = {1'b0, count_q} + {4'd0, len_q, 1'b0} + 8'd1;

  always_comb begin
    stat_o.no_req    = !char_i.valid;
    stat_o.out_busy  = out_valid_q && !ival_o.ready;
    stat_o.skip      = halt_q || (!is_sym_q && !is_space_q);
    stat_o.space     = is_space_q;
    stat_o.nofit     = need > (CountW+1)'(MAX_INTERVALS);
    stat_o.noheld    = held_q == HELD_NONE;
    stat_o.last_elem = (elem_q + 3'd1) >= len_q;
    stat_o.not_eot   = !eot_q;
  end

  always_comb begin
    unique case (ctrl_i.units)
      U_HELD:  units = (held_q == HELD_SEVEN) ? 3'd7 : 3'd3;
      U_ELEM:  units = dash_q[elem_q] ? 3'd3 : 3'd1;
      U_ONE:   units = 3'd1;
      U_SEVEN: units = 3'd7;
      default: units = 3'd1;
    endcase
  end

  always_comb begin
    held_d  = held_q;
    count_d = count_q;
    halt_d  = halt_q;
    unique case (ctrl_i.act)
      A_NONE:    ;
      A_UPGRADE: if (held_q != HELD_NONE) held_d = HELD_SEVEN;
      A_HALT:    halt_d = 1'b1;
      A_INC:     ;
      A_COMMIT:  begin
        held_d  = HELD_THREE;
        count_d = count_q + {3'd0, len_q, 1'b0};
      end
      A_CLEAR:   begin
        held_d  = HELD_NONE;
        count_d = '0;
        halt_d  = 1'b0;
      end
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q      <= UNIT_RESET;
      held_q      <= HELD_NONE;
      count_q     <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) unit_q <= cfg_wdata_i;
      held_q  <= held_d;
      count_q <= count_d;
      halt_q  <= halt_d;
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (ival_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req) begin
      eot_q      <= char_i.end_of_text;
      is_space_q <= char_i.char_code == SPACE_CODE;
      is_sym_q   <= sym.valid;
      len_q      <= sym.len;
      dash_q     <= sym.dash;
      elem_q     <= '0;
    end else if (ctrl_i.act == A_INC) begin
      elem_q <= elem_q + 3'd1;
    end
    if (ctrl_i.emit) begin
      dur_q  <= DurW'(units) * DurW'(unit_q);
      key_q  <= ctrl_i.key_on;
      last_q <= ctrl_i.last;
    end
  end

endmodule

// ===== src/morse_timing_encoder.sv =====
// Microcoded sequencer: one control step per cycle, one interval emitted per emitting step;
// an emitting step waits while the output register is full. An ignored character that ends
// the text sends out only the end gap, and only when a gap is held.
// Reset (async, active low) clears the step counter, held gap, count and halt flag;
// unit_time returns to 128.
module morse_timing_encoder import mte_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  mte_char_if.sink         char_i,
  mte_ival_if.source       ival_o
);

  ctrl_t ctrl;
  stat_t stat;

  mte_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mte_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .char_i      (char_i),
    .ival_o      (ival_o)
  );

endmodule

// ===== sim/tb_morse_timing_encoder.sv =====
`timescale 1ns / 1ps

module tb_morse_timing_encoder;
  import mte_pkg::*;

  localparam int MaxIntervals = 64;
  localparam byte DashChar    = "-";
  localparam int SettleCycles = 40;
  localparam int MaxReports   = 10;

  typedef struct packed {
    logic [DurW-1:0] duration;
    logic            key_on;
    logic            last_interval;
  } interval_t;

  // letters A..Z then digits 0..9, element i = character i
  string morse_tab [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----."
  };

  class morse_scoreboard;
    logic [UnitW-1:0]  unit_ms;
    held_e             held;
    logic [CountW-1:0] ival_count;
    bit                halted;
    interval_t         expected_q [$];
    int                errors;
    int                num_seen;

    function new();
      unit_ms    = UNIT_RESET;
      held       = HELD_NONE;
      ival_count = '0;
      halted     = 1'b0;
      errors     = 0;
      num_seen   = 0;
    endfunction

    function int symbol_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0") + 26;
      if (c >= "A" && c <= "Z") return int'(c - "A");
      if (c >= "a" && c <= "z") return int'(c - "a");
      return -1;
    endfunction

    function void push_interval(int units, logic on, logic last);
      interval_t e;
      e.duration      = DurW'(units * int'(unit_ms));
      e.key_on        = on;
      e.last_interval = last;
      expected_q.push_back(e);
    endfunction

    function void note_char(logic [7:0] c, logic eot);
      int    idx;
      int    n;
      string code;
      if (!halted) begin
        if (c == SPACE_CODE) begin
          if (held != HELD_NONE) held = HELD_SEVEN;
        end else begin
          idx = symbol_of(c);
          if (idx >= 0) begin
            code = morse_tab[idx];
            n    = code.len();
            if (int'(ival_count) + 2 * n + 1 > MaxIntervals) begin
              halted = 1'b1;
            end else begin
              if (held != HELD_NONE) push_interval((held == HELD_SEVEN) ? 7 : 3, 1'b0, 1'b0);
              for (int i = 0; i < n; i++) begin
                push_interval((code[i] == DashChar) ? 3 : 1, 1'b1, 1'b0);
                if (i + 1 < n) push_interval(1, 1'b0, 1'b0);
              end
              held       = HELD_THREE;
              ival_count = ival_count + CountW'(2 * n);
            end
          end
        end
      end
      if (eot) begin
        if (held != HELD_NONE) push_interval(7, 1'b0, 1'b1);
        held       = HELD_NONE;
        ival_count = '0;
        halted     = 1'b0;
      end
    endfunction

    function void check_interval(logic [DurW-1:0] dur, logic on, logic last);
      interval_t e;
      num_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("interval %0d unexpected: dur=%0d on=%0b last=%0b", num_seen, dur, on, last);
      end else begin
        e = expected_q.pop_front();
        if (dur !== e.duration || on !== e.key_on || last !== e.last_interval) begin
          errors++;
          if (errors <= MaxReports)
            $display("interval %0d: expected dur=%0d on=%0b last=%0b, got dur=%0d on=%0b last=%0b",
                     num_seen, e.duration, e.key_on, e.last_interval, dur, on, last);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [UnitW-1:0] cfg_wdata;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               items_sent;

  mte_char_if char_if ();
  mte_ival_if ival_if ();

  morse_scoreboard sb = new();

  morse_timing_encoder #(
    .MAX_INTERVALS(MaxIntervals)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .char_i     (char_if),
    .ival_o     (ival_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_morse_timing_encoder NOT OK");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    ival_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && ival_if.valid && ival_if.ready)
      sb.check_interval(ival_if.duration, ival_if.key_on, ival_if.last_interval);
  end

  task automatic send_char(logic [7:0] c, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      char_if.valid <= 1'b0;
    end
    @(negedge clk);
    char_if.valid       <= 1'b1;
    char_if.char_code   <= c;
    char_if.end_of_text <= eot;
    do @(posedge clk); while (!char_if.ready);
    sb.note_char(c, eot);
    items_sent++;
  endtask

  task automatic send_text(string s, logic eot_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eot_last && (i == s.len() - 1));
  endtask

  // hold requests back until every interval has drained, then let the block settle
  task automatic drain();
    @(negedge clk);
    char_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_unit(logic [UnitW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.unit_ms = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'("A" + $urandom_range(25));
    if (r < 45) return 8'("a" + $urandom_range(25));
    if (r < 65) return 8'("0" + $urandom_range(9));
    if (r < 85) return SPACE_CODE;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_message();
    int len;
    len = ($urandom_range(7) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++)
      send_char(pick_char(), i == len - 1);
  endtask

  task automatic run_directed();
    send_text(" ET  az!", 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("09", 1'b1);
    send_char(8'h00, 1'b1);        // end of text with nothing encoded
    send_text("000000", 1'b0);     // fills to 60 intervals
    send_text("5E M", 1'b1);       // no room for '5': rest ignored
    send_text("Z ", 1'b1);         // end of text on a space
  endtask

  initial begin
    logic [UnitW-1:0] units [6];
    int               quota;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    char_if.valid       = 1'b0;
    char_if.char_code   = '0;
    char_if.end_of_text = 1'b0;
    ival_if.ready       = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    items_sent          = 0;
    units = '{UNIT_RESET, 12'd4095, 12'd1, 12'd0, UnitW'($urandom_range(1, 4095)), 12'd3};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    run_directed();
    drain();

    quota = items_sent;
    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (p > 0) write_unit(units[p]);
      quota += 50;
      while (items_sent < quota) begin
        if ($urandom_range(19) == 0) drain();
        send_message();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_morse_timing_encoder OK");
    end else begin
      $display("tb_morse_timing_encoder NOT OK");
    end
    $finish;
  end

endmodule
